@@ rtl/tbd_pkg.sv @@
package tbd_pkg;

    localparam int unsigned ROUND_COUNT = 32;
    localparam int unsigned STAGE_COUNT = 2 * ROUND_COUNT;
    localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

    localparam int unsigned ADDR_W = 4;

    localparam logic [1:0] REG_KEY_ZERO  = 2'd0;
    localparam logic [1:0] REG_KEY_ONE   = 2'd1;
    localparam logic [1:0] REG_KEY_TWO   = 2'd2;
    localparam logic [1:0] REG_KEY_THREE = 2'd3;

    localparam logic [31:0] KEY_ZERO_RESET  = 32'd128;
    localparam logic [31:0] KEY_ONE_RESET   = 32'd129;
    localparam logic [31:0] KEY_TWO_RESET   = 32'd130;
    localparam logic [31:0] KEY_THREE_RESET = 32'd131;

    typedef struct packed {
        logic [31:0] cipher_first;
        logic [31:0] cipher_second;
    } cipher_t;

    typedef struct packed {
        logic [31:0] plain_first;
        logic [31:0] plain_second;
    } plain_t;

    // Working pair of words as it moves down the pipeline.
    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
    } word_pair_t;

    // Round sum used by round r: delta times the rounds still to go, wrapped.
    function automatic logic [31:0] round_sum(input int unsigned r);
        logic [63:0] prod;
        prod = 64'(TEA_DELTA) * 64'(ROUND_COUNT - r);
        return prod[31:0];
    endfunction

endpackage

@@ rtl/tbd_half_round.sv @@
module tbd_half_round (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     upd_second,
    input  logic [31:0]              sum,
    input  logic [31:0]              key_a,
    input  logic [31:0]              key_b,
    input  logic                     valid,
    input  tbd_pkg::word_pair_t      data,
    output logic                     result_valid,
    output tbd_pkg::word_pair_t      result
);

    logic                valid_reg;
    tbd_pkg::word_pair_t data_reg;
    tbd_pkg::word_pair_t data_next;
    logic [31:0]         src;
    logic [31:0]         dst;
    logic [31:0]         mix;
    logic [31:0]         diff;

    // One half of a round: the selected word drops by a mix of the other one.
    always_comb
    begin
        src  = upd_second ? data.first : data.second;
        dst  = upd_second ? data.second : data.first;
        mix  = ((src << 4) + key_a) ^ (src + sum) ^ ((src >> 5) + key_b);
        diff = dst - mix;
        data_next = data;
        if (upd_second)
        begin
            data_next.second = diff;
        end
        else
        begin
            data_next.first = diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

@@ rtl/tea_block_decrypt_core.sv @@
// Path: a block accepted at a clock edge is loaded into the first half-round stage, moves
// through each of the 2*ROUND_COUNT half-round stages in turn, and from the last one is
// loaded into the output register, which drives plain_data.
// Throughput: one block per cycle while the output is not stalled; a one-entry skid buffer
// at the output keeps the input stall a registered signal, so the 64-stage pipeline moves as one.
// Reset: rst_n clears every valid bit and loads the key registers with 128..131 at once.
module tea_block_decrypt_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cipher_valid,
    output logic                          cipher_stall,
    input  tbd_pkg::cipher_t              cipher_data,
    output logic                          plain_valid,
    input  logic                          plain_stall,
    output tbd_pkg::plain_t               plain_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbd_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [31:0] key_zero_reg;
    logic [31:0] key_one_reg;
    logic [31:0] key_two_reg;
    logic [31:0] key_three_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_zero_reg  <= tbd_pkg::KEY_ZERO_RESET;
            key_one_reg   <= tbd_pkg::KEY_ONE_RESET;
            key_two_reg   <= tbd_pkg::KEY_TWO_RESET;
            key_three_reg <= tbd_pkg::KEY_THREE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                tbd_pkg::REG_KEY_ZERO:  key_zero_reg  <= pwdata;
                tbd_pkg::REG_KEY_ONE:   key_one_reg   <= pwdata;
                tbd_pkg::REG_KEY_TWO:   key_two_reg   <= pwdata;
                tbd_pkg::REG_KEY_THREE: key_three_reg <= pwdata;
                default:                key_zero_reg  <= key_zero_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            tbd_pkg::REG_KEY_ZERO:  prdata = key_zero_reg;
            tbd_pkg::REG_KEY_ONE:   prdata = key_one_reg;
            tbd_pkg::REG_KEY_TWO:   prdata = key_two_reg;
            tbd_pkg::REG_KEY_THREE: prdata = key_three_reg;
            default:                prdata = '0;
        endcase
    end

    // Pipeline: stage 2r updates the second word of round r, stage 2r+1 the first.
    logic                advance;
    logic                skid_valid_reg;
    logic                stage_valid [tbd_pkg::STAGE_COUNT+1];
    tbd_pkg::word_pair_t stage_data  [tbd_pkg::STAGE_COUNT+1];

    assign advance      = !skid_valid_reg;
    assign cipher_stall = skid_valid_reg;

    assign stage_valid[0]       = cipher_valid;
    assign stage_data[0].first  = cipher_data.cipher_first;
    assign stage_data[0].second = cipher_data.cipher_second;

    for (genvar s = 0; s < tbd_pkg::STAGE_COUNT; s++)
    begin : g_stage
        localparam logic        UPD_SECOND = ((s % 2) == 0);
        localparam logic [31:0] SUM        = tbd_pkg::round_sum(s / 2);

        tbd_half_round u_half_round (
            .clk          (clk),
            .rst_n        (rst_n),
            .advance      (advance),
            .upd_second   (UPD_SECOND),
            .sum          (SUM),
            .key_a        (UPD_SECOND ? key_two_reg : key_zero_reg),
            .key_b        (UPD_SECOND ? key_three_reg : key_one_reg),
            .valid        (stage_valid[s]),
            .data         (stage_data[s]),
            .result_valid (stage_valid[s+1]),
            .result       (stage_data[s+1])
        );
    end

    // Output register with a one-entry skid buffer behind it.
    logic                out_valid_reg;
    tbd_pkg::word_pair_t out_data_reg;
    tbd_pkg::word_pair_t skid_data_reg;
    logic                take;
    logic                out_free;

    assign take     = stage_valid[tbd_pkg::STAGE_COUNT] && advance;
    assign out_free = !out_valid_reg || !plain_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= take;
            end
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : stage_data[tbd_pkg::STAGE_COUNT];
        end
        else if (take)
        begin
            skid_data_reg <= stage_data[tbd_pkg::STAGE_COUNT];
        end
    end

    assign plain_valid             = out_valid_reg;
    assign plain_data.plain_first  = out_data_reg.first;
    assign plain_data.plain_second = out_data_reg.second;

    // The skid entry only fills behind a waiting result.
    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register is empty");

    // A block leaving the pipeline while the output is stalled must land in the skid entry.
    a_stalled_take_kept : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && plain_stall && take) |=> skid_valid_reg)
        else $error("pipeline result dropped during output stall");

    // Draining the skid entry leaves a result on the output.
    a_skid_drain : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(skid_valid_reg) |-> plain_valid)
        else $error("skid entry drained without presenting a result");

endmodule
